// File: sv/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants for the sorted-squares merge block.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default depth of the element store (elements per run).
  localparam int MAX_LEN    = 64;
  // Default stored element width, two's complement.
  localparam int VALUE_BITS = 16;
  // Fixed width of the value field on the input port.
  localparam int VALUE_W    = 16;
  // Fixed width of the square field on the output port.
  localparam int SQUARE_W   = 31;

endpackage

// File: sv/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ssm_ram #(
  parameter int WIDTH = ssm_pkg::VALUE_BITS,
  parameter int DEPTH = ssm_pkg::MAX_LEN,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two read ports, registered read data
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: sv/sorted_squares_merge.sv
// ----------------------------------------------------------------------------
// sorted_squares_merge
// Loads a sorted run of signed values into a RAM, then emits their squares
// in non-decreasing order by a two-pointer merge out from the negative split.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | value[15:0] signed, last_in
//   out     | out_valid / out_ready| square[30:0], last_out, input_unsorted
//
// Loading accepts one input beat per cycle; the beat marked last_in closes the
// run. Emission then fetches the first pair from the registered RAM read and,
// for each result, steps through square, compare/select and output beat, with
// the multiplier stage registering both squares. Input is refused while a
// run is being emitted. A stalled output beat holds the merge. Reset clears
// the run state at once; the element store needs no clearing pass.
module sorted_squares_merge #(
  parameter int MAX_LEN    = ssm_pkg::MAX_LEN,
  parameter int VALUE_BITS = ssm_pkg::VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ssm_pkg::VALUE_W-1:0] value,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssm_pkg::SQUARE_W-1:0]  square,
  output logic                          last_out,
  output logic                          input_unsorted
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = 2 * VALUE_BITS;

  typedef enum logic [2:0] {
    S_LOAD, S_FETCH, S_MUL, S_PICK, S_SEND
  } state_t;

  state_t state;

  // run state while loading
  logic [CW-1:0]                load_count;
  logic [CW-1:0]                neg_count;
  logic                         still_in_prefix;
  logic signed [VALUE_BITS-1:0] prev_value;
  logic                         unsorted_seen;

  // merge state while emitting
  logic [CW-1:0]                left;
  logic [CW-1:0]                right;
  logic [CW-1:0]                run_len;
  logic [CW-1:0]                remaining;
  logic [PW-1:0]                prod_l;
  logic [PW-1:0]                prod_r;

  // load-side next values
  logic [31:0]                  raw_value;
  logic signed [VALUE_BITS-1:0] v_in;
  logic                         in_beat;
  logic                         store_ok;
  logic [CW-1:0]                load_count_next;
  logic [CW-1:0]                neg_count_next;
  logic                         still_in_prefix_next;
  logic                         unsorted_seen_next;

  // RAM ports
  logic [AW-1:0]                raddr_l;
  logic [AW-1:0]                raddr_r;
  logic signed [VALUE_BITS-1:0] rd_l;
  logic signed [VALUE_BITS-1:0] rd_r;
  logic signed [PW-1:0]         sq_l;
  logic signed [PW-1:0]         sq_r;

  // merge selection
  logic                         take_left;
  logic [PW-1:0]                pick_prod;
  logic [63:0]                  pick_ext;

  assign in_ready = (state == S_LOAD);
  assign in_beat  = in_valid && in_ready;

  // low VALUE_BITS of the field, two's complement
  assign raw_value = 32'(unsigned'(value));
  assign v_in      = raw_value[VALUE_BITS-1:0];
  assign store_ok  = (load_count < CW'(MAX_LEN));

  // running prefix, count and order check
  always_comb begin
    load_count_next      = load_count;
    neg_count_next       = neg_count;
    still_in_prefix_next = still_in_prefix;
    unsorted_seen_next   = unsorted_seen;
    if (store_ok) begin
      load_count_next = load_count + CW'(1);
      if (load_count != '0 && v_in < prev_value) begin
        unsorted_seen_next = 1'b1;
      end
      if (still_in_prefix && v_in < 0) begin
        neg_count_next = neg_count + CW'(1);
      end else begin
        still_in_prefix_next = 1'b0;
      end
    end
  end

  // read addresses follow the pointers; out-of-run reads are parked at 0
  assign raddr_l = (left == '0) ? '0 : AW'(left - CW'(1));
  assign raddr_r = (right >= run_len) ? '0 : AW'(right);

  ssm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .we      (in_beat && store_ok),
    .waddr   (AW'(load_count)),
    .wdata   (v_in),
    .raddr_a (raddr_l),
    .raddr_b (raddr_r),
    .rdata_a (rd_l),
    .rdata_b (rd_r)
  );

  // squares of both heads
  assign sq_l = PW'(rd_l) * PW'(rd_l);
  assign sq_r = PW'(rd_r) * PW'(rd_r);

  // smaller square first, ties to the left side
  always_comb begin
    take_left = (left != '0) && ((right >= run_len) || (prod_l <= prod_r));
    pick_prod = take_left ? prod_l : prod_r;
    pick_ext  = 64'(pick_prod);
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_LOAD;
      load_count      <= '0;
      neg_count       <= '0;
      still_in_prefix <= 1'b1;
      prev_value      <= '0;
      unsorted_seen   <= 1'b0;
      out_valid       <= 1'b0;
      left            <= '0;
      right           <= '0;
      run_len         <= '0;
      remaining       <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (last_in) begin
              // hand the run to the merge and clear the load state
              left            <= neg_count_next;
              right           <= neg_count_next;
              run_len         <= load_count_next;
              remaining       <= load_count_next;
              input_unsorted  <= unsorted_seen_next;
              load_count      <= '0;
              neg_count       <= '0;
              still_in_prefix <= 1'b1;
              prev_value      <= '0;
              unsorted_seen   <= 1'b0;
              state           <= S_FETCH;
            end else begin
              if (store_ok) begin
                prev_value <= v_in;
              end
              load_count      <= load_count_next;
              neg_count       <= neg_count_next;
              still_in_prefix <= still_in_prefix_next;
              unsorted_seen   <= unsorted_seen_next;
            end
          end
        end
        S_FETCH: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod_l <= unsigned'(sq_l);
          prod_r <= unsigned'(sq_r);
          state  <= S_PICK;
        end
        S_PICK: begin
          square    <= pick_ext[ssm_pkg::SQUARE_W-1:0];
          last_out  <= (remaining == CW'(1));
          remaining <= remaining - CW'(1);
          if (take_left) begin
            left <= left - CW'(1);
          end else begin
            right <= right + CW'(1);
          end
          out_valid <= 1'b1;
          state     <= S_SEND;
        end
        S_SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= last_out ? S_LOAD : S_MUL;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// File: sv/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks on the sorted-squares merge, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          last_in,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ssm_pkg::SQUARE_W-1:0]  square,
  input logic                          last_out,
  input logic                          input_unsorted
);

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(square) && $stable(last_out)
      && $stable(input_unsorted))
    else $error("output beat changed while stalled");

  // loading and emitting never overlap
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is shown");

  // the closing input beat stops further loading
  a_close_run: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_in |=> !in_ready && !out_valid)
    else $error("block still loading after the last beat");

  // the final result hands the block back to loading
  a_run_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> in_ready && !out_valid)
    else $error("block not ready after the final result");

  // reset leaves the block ready to load and silent
  a_after_rst: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind sorted_squares_merge ssm_checker u_ssm_checker (.*);
